// File: rtl/ifrm_pkg.sv
package ifrm_pkg;

  // Operation codes carried on func.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MATCH = 1'b1;

  // Address family codes.
  localparam logic [1:0] FAM_ANY = 2'd0;
  localparam logic [1:0] FAM_V4  = 2'd1;
  localparam logic [1:0] FAM_V6  = 2'd2;

  // Rule memory word. The clearing pass after reset zeroes the whole word,
  // valid included, so address data read as zero until a rule is written.
  typedef struct packed {
    logic [63:0] remote_high;
    logic [63:0] remote_low;
    logic [63:0] ue_high;
    logic [63:0] ue_low;
    logic [63:0] ports;
    logic [7:0]  remote_len;
    logic [7:0]  ue_len;
    logic [1:0]  fam;
    logic        assigned;
    logic        valid;
  } rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;     // write an empty rule at the sweep address
    logic wr_rule;    // write the request's rule at entry_index
    logic rd_en;      // read the rule at the sweep address
    logic load_flow;  // capture the flow fields and clear the hit flag
  } ifrm_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RESP,
    ST_SCAN,
    ST_FLUSH,
    ST_RESP
  } ifrm_state_t;

  // Leading-bit mask over a 128-bit address: bit j is set when it lies
  // within the first len bits. Lengths above 128 give all ones.
  function automatic logic [127:0] prefix_mask(input logic [7:0] len);
    logic [127:0] m;
    for (int j = 0; j < 128; j++) begin
      m[j] = (8'(127 - j) < len);
    end
    return m;
  endfunction

  // Left-aligned comparison operand: an IPv4 address takes the leading
  // 32 bits, so a 128-bit mask serves both families.
  function automatic logic [127:0] addr_operand(input logic [1:0] fam,
                                                input logic [63:0] high,
                                                input logic [63:0] low);
    logic [127:0] a;
    if (fam == FAM_V4) begin
      a = {low[31:0], 96'd0};
    end else begin
      a = {high, low};
    end
    return a;
  endfunction

endpackage

// File: rtl/ifrm_ctrl.sv
module ifrm_ctrl
  import ifrm_pkg::*;
#(
  parameter int RULE_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   func,
  output logic                   busy,
  output logic                   done,
  output ifrm_cmd_t              cmd,
  output logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] slot_addr
);

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RULE_SLOTS - 1);

  ifrm_state_t       state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic              accept;

  assign accept    = start && !busy;
  assign slot_addr = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and sweep counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_CLEAR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (start) begin
          state_next = (func == FUNC_MATCH) ? ST_SCAN : ST_WR_RESP;
        end
      end
      ST_WR_RESP: state_next = ST_IDLE;
      ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          cnt_next   = '0;
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy          = 1'b1;
    done          = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.wr_rule   = start && (func == FUNC_WRITE);
        cmd.load_flow = start;
      end
      ST_WR_RESP: done = 1'b1;
      ST_SCAN:    cmd.rd_en = 1'b1;
      ST_FLUSH:   ;
      ST_RESP:    done = 1'b1;
      default:    ;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("request accepted but block not busy");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("block not free after result");

endmodule

// File: rtl/ifrm_dp.sv
module ifrm_dp
  import ifrm_pkg::*;
#(
  parameter int RULE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  ifrm_cmd_t   cmd,
  input  logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] slot_addr,
  input  logic [5:0]  entry_index,
  input  logic [1:0]  family,
  input  logic [63:0] remote_addr_high,
  input  logic [63:0] remote_addr_low,
  input  logic [63:0] ue_addr_high,
  input  logic [63:0] ue_addr_low,
  input  logic [7:0]  remote_prefix_len,
  input  logic [7:0]  ue_prefix_len,
  input  logic        ue_assigned,
  input  logic [63:0] port_word,
  output logic        matched
);

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  rule_t             mem [RULE_SLOTS];
  rule_t             rd_data;
  logic              rd_valid;
  logic              hit;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  rule_t             wr_data;

  // Captured flow.
  logic [1:0]        flow_fam;
  logic [127:0]      flow_remote;
  logic [127:0]      flow_ue;
  logic              flow_assigned;
  logic [15:0]       flow_rport;
  logic [15:0]       flow_uport;

  logic              fam_ok, remote_ok, ue_ok, ports_ok, slot_match;
  logic [127:0]      rule_remote, rule_ue;

  // One write port, shared by the clearing sweep and rule writes.
  always_comb begin
    wr_data             = '0;
    wr_en               = 1'b0;
    wr_addr             = slot_addr;
    if (cmd.clr_we) begin
      wr_en = 1'b1;
    end else if (cmd.wr_rule && (int'(entry_index) < RULE_SLOTS)) begin
      wr_en               = 1'b1;
      wr_addr             = SLOT_W'(entry_index);
      wr_data.remote_high = remote_addr_high;
      wr_data.remote_low  = remote_addr_low;
      wr_data.ue_high     = ue_addr_high;
      wr_data.ue_low      = ue_addr_low;
      wr_data.ports       = port_word;
      wr_data.remote_len  = remote_prefix_len;
      wr_data.ue_len      = ue_prefix_len;
      wr_data.fam         = family;
      wr_data.assigned    = ue_assigned;
      wr_data.valid       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flow) begin
      flow_fam      <= family;
      flow_remote   <= addr_operand(family, remote_addr_high, remote_addr_low);
      flow_ue       <= addr_operand(family, ue_addr_high, ue_addr_low);
      flow_assigned <= ue_assigned;
      flow_rport    <= port_word[15:0];
      flow_uport    <= port_word[31:16];
    end
  end

  // Compare the rule read last cycle against the captured flow.
  always_comb begin
    rule_remote = addr_operand(flow_fam, rd_data.remote_high, rd_data.remote_low);
    rule_ue     = addr_operand(flow_fam, rd_data.ue_high, rd_data.ue_low);
    fam_ok      = rd_data.valid
                  && ((flow_fam == FAM_V4) || (flow_fam == FAM_V6))
                  && ((rd_data.fam == FAM_ANY) || (rd_data.fam == flow_fam));
    remote_ok   = (((flow_remote ^ rule_remote) & prefix_mask(rd_data.remote_len))
                   == '0);
    if (rd_data.assigned) begin
      ue_ok = flow_assigned;
    end else begin
      ue_ok = (((flow_ue ^ rule_ue) & prefix_mask(rd_data.ue_len)) == '0);
    end
    ports_ok    = (flow_rport >= rd_data.ports[15:0])
                  && (flow_rport <= rd_data.ports[31:16])
                  && (flow_uport >= rd_data.ports[47:32])
                  && (flow_uport <= rd_data.ports[63:48]);
    slot_match  = fam_ok && remote_ok && ue_ok && ports_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.load_flow) begin
        hit <= 1'b0;
      end else if (rd_valid && slot_match) begin
        hit <= 1'b1;
      end
    end
  end

  assign matched = hit;

  a_hit_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.load_flow |=> !hit) else $error("hit flag not cleared on new request");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_we |-> !cmd.wr_rule && !cmd.rd_en)
    else $error("clearing sweep overlaps a rule access");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !cmd.wr_rule && !cmd.load_flow)
    else $error("rule scan overlaps a new request");

endmodule

// File: rtl/ip_flow_rule_matcher_top.sv
// Channel   Handshake        Payload
// -------   --------------   ------------------------------------------------
// request   start / busy     func, entry_index, family, remote/ue addresses,
//                            prefix lengths, ue_assigned, port_word
// result    done (strobe)    matched
//
// A rule write stores the rule at the accepting edge, and done follows in
// the next cycle with matched low. A match scans every slot of the rule
// memory, one slot per cycle through its single read port, then passes
// through a flush state to the result state, where done rises; busy falls
// as the block returns to idle after that result strobe.
// After reset the block sweeps the rule memory to clear every valid flag;
// busy stays high during that sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ip_flow_rule_matcher_top
  import ifrm_pkg::*;
#(
  parameter int RULE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        func,
  input  logic [5:0]  entry_index,
  input  logic [1:0]  family,
  input  logic [63:0] remote_addr_high,
  input  logic [63:0] remote_addr_low,
  input  logic [63:0] ue_addr_high,
  input  logic [63:0] ue_addr_low,
  input  logic [7:0]  remote_prefix_len,
  input  logic [7:0]  ue_prefix_len,
  input  logic        ue_assigned,
  input  logic [63:0] port_word,
  output logic        matched
);

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  // The controller owns the sweep counter that addresses the rule memory,
  // both for the clearing pass and for the match scan.
  ifrm_cmd_t         cmd;
  logic [SLOT_W-1:0] slot_addr;

  ifrm_ctrl #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .slot_addr (slot_addr)
  );

  // The datapath holds the rule memory, the captured flow and the hit flag.
  // Rules are compared one per cycle and any hit is remembered until the
  // result strobe; since the outcome is an OR over all slots, the scan
  // always runs to the end and the latency does not depend on the data.
  ifrm_dp #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .slot_addr         (slot_addr),
    .entry_index       (entry_index),
    .family            (family),
    .remote_addr_high  (remote_addr_high),
    .remote_addr_low   (remote_addr_low),
    .ue_addr_high      (ue_addr_high),
    .ue_addr_low       (ue_addr_low),
    .remote_prefix_len (remote_prefix_len),
    .ue_prefix_len     (ue_prefix_len),
    .ue_assigned       (ue_assigned),
    .port_word         (port_word),
    .matched           (matched)
  );

endmodule
